/* rtl/lb_pkg.sv */
// shared constants and types for the liang-barsky line clipper
package lb_pkg;

  // coordinate width, fraction bits of the clip parameter
  localparam int CW    = 16;
  localparam int PFB   = 16;
  // magnitude width of p, q and of a segment delta
  localparam int AW    = CW + 1;
  // divider remainder width
  localparam int RW    = CW + 2;
  // clip parameter width, holds 1.0 and the above-one marker
  localparam int TW    = PFB + 1;
  // divider stages, one quotient bit each
  localparam int NSTEP = PFB + 1;
  // product width of t times a delta magnitude
  localparam int PW    = TW + AW;
  // configuration index width
  localparam int IW    = 2;

  localparam logic [TW-1:0] T_ONE = TW'(1) << PFB;
  localparam logic [TW-1:0] T_BIG = T_ONE + TW'(1);

  // register indexes
  localparam logic [IW-1:0] REG_LEFT   = 2'd0;
  localparam logic [IW-1:0] REG_BOTTOM = 2'd1;
  localparam logic [IW-1:0] REG_RIGHT  = 2'd2;
  localparam logic [IW-1:0] REG_TOP    = 2'd3;

  // window reset values
  localparam logic signed [CW-1:0] RST_LEFT   = CW'(3200);
  localparam logic signed [CW-1:0] RST_BOTTOM = CW'(2400);
  localparam logic signed [CW-1:0] RST_RIGHT  = CW'(9600);
  localparam logic signed [CW-1:0] RST_TOP    = CW'(7200);

  // per-edge classification
  typedef struct packed {
    logic pz;    // p is zero
    logic qneg;  // q is negative
    logic pneg;  // p is negative
    logic neg;   // ratio is strictly negative
    logic big;   // |q| > |p|, ratio above one
  } bflag_t;

  // item data carried alongside the dividers
  typedef struct packed {
    logic signed [CW-1:0] x1;
    logic signed [CW-1:0] y1;
    logic signed [CW:0]   dx;
    logic signed [CW:0]   dy;
    bflag_t [3:0]         fl;
  } side_t;

  // merged clip parameters of one segment
  typedef struct packed {
    logic                 vis;
    logic [TW-1:0]        t_in;
    logic [TW-1:0]        t_out;
    logic signed [CW-1:0] x1;
    logic signed [CW-1:0] y1;
    logic signed [CW:0]   dx;
    logic signed [CW:0]   dy;
  } seg_t;

endpackage

/* rtl/line_clip_liang_barsky.sv */
// top level of the liang-barsky line clipper
//
//  channel  ports                                   handshake
//  input    in_start_x/y, in_end_x/y                start, busy (busy held low)
//  result   out_visible, out_clip_start/end_x/y     out_valid strobe, one cycle
//  config   cfg_index, cfg_data                     cfg_we, applied at the edge
//
// one segment enters per cycle; each gives one result after its pipeline
// (setup stage, 17 divider stages of one quotient bit each, merge stage,
// product stage, round and add stage). rst_n clears the valid bits and
// loads the window reset values; data registers are not reset.
// the receiver cannot stall, so the pipeline never halts and busy stays low.
module line_clip_liang_barsky (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  logic signed [lb_pkg::CW-1:0]  in_start_x,
  input  logic signed [lb_pkg::CW-1:0]  in_start_y,
  input  logic signed [lb_pkg::CW-1:0]  in_end_x,
  input  logic signed [lb_pkg::CW-1:0]  in_end_y,
  output logic                          out_valid,
  output logic                          out_visible,
  output logic signed [lb_pkg::CW-1:0]  out_clip_start_x,
  output logic signed [lb_pkg::CW-1:0]  out_clip_start_y,
  output logic signed [lb_pkg::CW-1:0]  out_clip_end_x,
  output logic signed [lb_pkg::CW-1:0]  out_clip_end_y,
  input  logic                          cfg_we,
  input  logic [lb_pkg::IW-1:0]         cfg_index,
  input  logic [lb_pkg::CW-1:0]         cfg_data
);

  localparam int LAT = lb_pkg::NSTEP + 4;

  logic signed [lb_pkg::CW-1:0]  left_r, bottom_r, right_r, top_r;
  logic [LAT-1:0]                vld_r, vld_nxt;
  lb_pkg::side_t                 side;
  lb_pkg::side_t                 side_r [lb_pkg::NSTEP];
  logic [3:0][lb_pkg::AW-1:0]    ap, aq;
  logic [3:0][lb_pkg::TW-1:0]    quo;
  lb_pkg::seg_t                  seg;

  assign busy = 1'b0;

  // window registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      left_r   <= lb_pkg::RST_LEFT;
      bottom_r <= lb_pkg::RST_BOTTOM;
      right_r  <= lb_pkg::RST_RIGHT;
      top_r    <= lb_pkg::RST_TOP;
    end else if (cfg_we) begin
      case (cfg_index)
        lb_pkg::REG_LEFT:   left_r   <= cfg_data;
        lb_pkg::REG_BOTTOM: bottom_r <= cfg_data;
        lb_pkg::REG_RIGHT:  right_r  <= cfg_data;
        lb_pkg::REG_TOP:    top_r    <= cfg_data;
        default:            ;
      endcase
    end
  end

  // valid bits travel with the item
  assign vld_nxt = {vld_r[LAT-2:0], start & ~busy};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  lb_setup u_setup (
    .clk        (clk),
    .x1         (in_start_x),
    .y1         (in_start_y),
    .x2         (in_end_x),
    .y2         (in_end_y),
    .win_left   (left_r),
    .win_bottom (bottom_r),
    .win_right  (right_r),
    .win_top    (top_r),
    .side       (side),
    .ap         (ap),
    .aq         (aq)
  );

  // one divider for each window edge, in parallel
  for (genvar i = 0; i < 4; i++) begin : g_div
    lb_div u_div (
      .clk (clk),
      .aq  (aq[i]),
      .ap  (ap[i]),
      .quo (quo[i])
    );
  end

  // item data delayed to match the dividers
  always_ff @(posedge clk) begin
    side_r[0] <= side;
    for (int s = 1; s < lb_pkg::NSTEP; s++) begin
      side_r[s] <= side_r[s-1];
    end
  end

  lb_merge u_merge (
    .clk  (clk),
    .side (side_r[lb_pkg::NSTEP-1]),
    .quo  (quo),
    .seg  (seg)
  );

  lb_interp u_interp (
    .clk (clk),
    .seg (seg),
    .vis (out_visible),
    .sx  (out_clip_start_x),
    .sy  (out_clip_start_y),
    .ex  (out_clip_end_x),
    .ey  (out_clip_end_y)
  );

  assign out_valid = vld_r[LAT-1];

  // a rejected segment carries zero endpoints
  a_reject_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_visible |->
      out_clip_start_x == '0 && out_clip_start_y == '0 &&
      out_clip_end_x == '0 && out_clip_end_y == '0)
    else $error("rejected segment with nonzero endpoints");

  // a visible segment has entry not past exit, exit not past one
  a_param_order: assert property (@(posedge clk) disable iff (!rst_n)
    vld_r[LAT-3] && seg.vis |-> seg.t_in <= seg.t_out && seg.t_out <= lb_pkg::T_ONE)
    else $error("visible segment with bad clip parameters");

  // visibility flag reaches the output one stage after the products
  a_vis_track: assert property (@(posedge clk) disable iff (!rst_n)
    vld_r[LAT-3] ##2 out_valid |-> out_visible == $past(seg.vis, 2))
    else $error("visibility lost between merge and output");

endmodule

/* rtl/lb_setup.sv */
// first stage: edge distances, directions and their magnitudes
module lb_setup (
  input  logic                              clk,
  input  logic signed [lb_pkg::CW-1:0]      x1,
  input  logic signed [lb_pkg::CW-1:0]      y1,
  input  logic signed [lb_pkg::CW-1:0]      x2,
  input  logic signed [lb_pkg::CW-1:0]      y2,
  input  logic signed [lb_pkg::CW-1:0]      win_left,
  input  logic signed [lb_pkg::CW-1:0]      win_bottom,
  input  logic signed [lb_pkg::CW-1:0]      win_right,
  input  logic signed [lb_pkg::CW-1:0]      win_top,
  output lb_pkg::side_t                     side,
  output logic [3:0][lb_pkg::AW-1:0]        ap,
  output logic [3:0][lb_pkg::AW-1:0]        aq
);

  logic signed [lb_pkg::CW:0]   dx, dy;
  logic signed [lb_pkg::CW:0]   p [4];
  logic signed [lb_pkg::CW:0]   q [4];
  lb_pkg::side_t                side_nxt;
  logic [3:0][lb_pkg::AW-1:0]   ap_nxt, aq_nxt;
  lb_pkg::side_t                side_r;
  logic [3:0][lb_pkg::AW-1:0]   ap_r, aq_r;

  // p and q for left, right, bottom, top
  always_comb begin
    dx   = {x2[lb_pkg::CW-1], x2} - {x1[lb_pkg::CW-1], x1};
    dy   = {y2[lb_pkg::CW-1], y2} - {y1[lb_pkg::CW-1], y1};
    p[0] = -dx;
    q[0] = {x1[lb_pkg::CW-1], x1} - {win_left[lb_pkg::CW-1], win_left};
    p[1] = dx;
    q[1] = {win_right[lb_pkg::CW-1], win_right} - {x1[lb_pkg::CW-1], x1};
    p[2] = -dy;
    q[2] = {y1[lb_pkg::CW-1], y1} - {win_bottom[lb_pkg::CW-1], win_bottom};
    p[3] = dy;
    q[3] = {win_top[lb_pkg::CW-1], win_top} - {y1[lb_pkg::CW-1], y1};
  end

  // magnitudes and per-edge flags
  always_comb begin
    side_nxt.x1 = x1;
    side_nxt.y1 = y1;
    side_nxt.dx = dx;
    side_nxt.dy = dy;
    for (int i = 0; i < 4; i++) begin
      ap_nxt[i] = p[i][lb_pkg::CW] ? lb_pkg::AW'(-p[i]) : lb_pkg::AW'(p[i]);
      aq_nxt[i] = q[i][lb_pkg::CW] ? lb_pkg::AW'(-q[i]) : lb_pkg::AW'(q[i]);
      side_nxt.fl[i].pz   = (p[i] == '0);
      side_nxt.fl[i].qneg = q[i][lb_pkg::CW];
      side_nxt.fl[i].pneg = p[i][lb_pkg::CW];
      side_nxt.fl[i].neg  = (q[i] != '0) && (q[i][lb_pkg::CW] != p[i][lb_pkg::CW]);
      side_nxt.fl[i].big  = aq_nxt[i] > ap_nxt[i];
    end
  end

  always_ff @(posedge clk) begin
    side_r <= side_nxt;
    ap_r   <= ap_nxt;
    aq_r   <= aq_nxt;
  end

  assign side = side_r;
  assign ap   = ap_r;
  assign aq   = aq_r;

endmodule

/* rtl/lb_div.sv */
// pipelined restoring divider, |q| * 2^PFB / |p|, one quotient bit per stage
module lb_div (
  input  logic                     clk,
  input  logic [lb_pkg::AW-1:0]    aq,
  input  logic [lb_pkg::AW-1:0]    ap,
  output logic [lb_pkg::TW-1:0]    quo
);

  logic [lb_pkg::RW-1:0] rem_r [lb_pkg::NSTEP];
  logic [lb_pkg::AW-1:0] den_r [lb_pkg::NSTEP];
  logic [lb_pkg::TW-1:0] quo_r [lb_pkg::NSTEP];

  for (genvar s = 0; s < lb_pkg::NSTEP; s++) begin : g_stage
    logic [lb_pkg::RW-1:0] rin;
    logic [lb_pkg::AW-1:0] din;
    logic [lb_pkg::TW-1:0] qin;
    logic                  ge;
    logic [lb_pkg::RW-1:0] rem_nxt;
    logic [lb_pkg::TW-1:0] quo_nxt;

    // the first stage gives the integer bit, later ones shift first
    if (s == 0) begin : g_first
      assign rin = lb_pkg::RW'(aq);
      assign din = ap;
      assign qin = '0;
    end else begin : g_next
      assign rin = {rem_r[s-1][lb_pkg::RW-2:0], 1'b0};
      assign din = den_r[s-1];
      assign qin = quo_r[s-1];
    end

    // trial subtract
    always_comb begin
      ge      = rin >= lb_pkg::RW'(din);
      rem_nxt = ge ? rin - lb_pkg::RW'(din) : rin;
      quo_nxt = {qin[lb_pkg::TW-2:0], ge};
    end

    always_ff @(posedge clk) begin
      rem_r[s] <= rem_nxt;
      den_r[s] <= din;
      quo_r[s] <= quo_nxt;
    end
  end

  assign quo = quo_r[lb_pkg::NSTEP-1];

endmodule

/* rtl/lb_merge.sv */
// entry and exit parameters from the ratio of each window edge, reject test
module lb_merge (
  input  logic                           clk,
  input  lb_pkg::side_t                  side,
  input  logic [3:0][lb_pkg::TW-1:0]     quo,
  output lb_pkg::seg_t                   seg
);

  lb_pkg::seg_t          seg_nxt;
  lb_pkg::seg_t          seg_r;
  logic [lb_pkg::TW-1:0] t;
  logic [lb_pkg::TW-1:0] t_in;
  logic [lb_pkg::TW-1:0] t_out;
  logic                  rej;

  // walk the edges, raising entry and lowering exit
  always_comb begin
    t_in  = '0;
    t_out = lb_pkg::T_ONE;
    rej   = 1'b0;
    t     = '0;
    for (int i = 0; i < 4; i++) begin
      t = side.fl[i].big ? lb_pkg::T_BIG : quo[i];
      if (side.fl[i].pz) begin
        if (side.fl[i].qneg) rej = 1'b1;
      end else if (side.fl[i].pneg) begin
        if (!side.fl[i].neg && (t > t_in)) t_in = t;
      end else begin
        if (side.fl[i].neg) rej = 1'b1;
        else if (t < t_out) t_out = t;
      end
    end
    if (t_in > t_out) rej = 1'b1;
    seg_nxt.vis   = !rej;
    seg_nxt.t_in  = t_in;
    seg_nxt.t_out = t_out;
    seg_nxt.x1    = side.x1;
    seg_nxt.y1    = side.y1;
    seg_nxt.dx    = side.dx;
    seg_nxt.dy    = side.dy;
  end

  always_ff @(posedge clk) begin
    seg_r <= seg_nxt;
  end

  assign seg = seg_r;

endmodule

/* rtl/lb_interp.sv */
// endpoint interpolation: product stage, then round and add stage
module lb_interp (
  input  logic                           clk,
  input  lb_pkg::seg_t                   seg,
  output logic                           vis,
  output logic signed [lb_pkg::CW-1:0]   sx,
  output logic signed [lb_pkg::CW-1:0]   sy,
  output logic signed [lb_pkg::CW-1:0]   ex,
  output logic signed [lb_pkg::CW-1:0]   ey
);

  logic [lb_pkg::AW-1:0]        adx, ady;
  logic [3:0][lb_pkg::PW-1:0]   prod_nxt, prod_r;
  logic                         dxn_r, dyn_r, vis_a_r;
  logic signed [lb_pkg::CW-1:0] x1_r, y1_r;
  logic [lb_pkg::RW-1:0]        off [4];
  logic [lb_pkg::RW-1:0]        base [4];
  logic [lb_pkg::RW-1:0]        res [4];
  logic [lb_pkg::PW-1:0]        half;
  logic                         dneg [4];
  logic [3:0][lb_pkg::CW-1:0]   pt_nxt, pt_r;
  logic                         vis_r;

  // delta magnitudes and the four products
  always_comb begin
    adx = seg.dx[lb_pkg::CW] ? lb_pkg::AW'(-seg.dx) : lb_pkg::AW'(seg.dx);
    ady = seg.dy[lb_pkg::CW] ? lb_pkg::AW'(-seg.dy) : lb_pkg::AW'(seg.dy);
    prod_nxt[0] = lb_pkg::PW'(seg.t_in)  * lb_pkg::PW'(adx);
    prod_nxt[1] = lb_pkg::PW'(seg.t_in)  * lb_pkg::PW'(ady);
    prod_nxt[2] = lb_pkg::PW'(seg.t_out) * lb_pkg::PW'(adx);
    prod_nxt[3] = lb_pkg::PW'(seg.t_out) * lb_pkg::PW'(ady);
  end

  always_ff @(posedge clk) begin
    prod_r  <= prod_nxt;
    dxn_r   <= seg.dx[lb_pkg::CW];
    dyn_r   <= seg.dy[lb_pkg::CW];
    x1_r    <= seg.x1;
    y1_r    <= seg.y1;
    vis_a_r <= seg.vis;
  end

  // round to nearest, apply the delta sign, zero a rejected segment
  always_comb begin
    half    = lb_pkg::PW'(1) << (lb_pkg::PFB - 1);
    base[0] = lb_pkg::RW'(x1_r);
    base[1] = lb_pkg::RW'(y1_r);
    base[2] = lb_pkg::RW'(x1_r);
    base[3] = lb_pkg::RW'(y1_r);
    dneg[0] = dxn_r;
    dneg[1] = dyn_r;
    dneg[2] = dxn_r;
    dneg[3] = dyn_r;
    for (int i = 0; i < 4; i++) begin
      off[i]    = lb_pkg::RW'((prod_r[i] + half) >> lb_pkg::PFB);
      res[i]    = dneg[i] ? base[i] - off[i] : base[i] + off[i];
      pt_nxt[i] = vis_a_r ? res[i][lb_pkg::CW-1:0] : '0;
    end
  end

  always_ff @(posedge clk) begin
    pt_r  <= pt_nxt;
    vis_r <= vis_a_r;
  end

  assign vis = vis_r;
  assign sx  = pt_r[0];
  assign sy  = pt_r[1];
  assign ex  = pt_r[2];
  assign ey  = pt_r[3];

endmodule
